### sv/mi3_pkg.sv
// Shared constants and types for the 3x3 fixed-point matrix inverse.
// Used by every module of the block; no dependencies.
package mi3_pkg;

    localparam int unsigned NUM_ELEM   = 9;    // matrix elements and divider lanes
    localparam int unsigned NUM_TERM   = 3;    // determinant terms
    localparam int unsigned DIV_BITS   = 33;   // quotient bits per lane
    localparam int unsigned LANE_LAT   = DIV_BITS + 1;
    localparam int unsigned FIFO_DEPTH = 64;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned CREDIT_W   = FIFO_AW + 1;

    // cofactor k = m[A]*m[B] - m[C]*m[D], element index = row*3 + column
    localparam int COF_A [NUM_ELEM] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
    localparam int COF_B [NUM_ELEM] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
    localparam int COF_C [NUM_ELEM] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
    localparam int COF_D [NUM_ELEM] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

    typedef struct packed {
        logic valid;
        logic singular;
    } t_ctl;

    typedef struct packed {
        logic [NUM_ELEM-1:0][31:0] r;
        logic                      singular;
        logic                      saturated;
    } t_res;

endpackage

### sv/mi3_front.sv
// Front end: cofactor products, cofactors, determinant and magnitudes.
// Six register stages; depends on mi3_pkg.
module mi3_front import mi3_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [31:0] i_m    [NUM_ELEM],
    output t_ctl               o_ctl,
    output logic        [96:0] o_dmag,
    output logic        [63:0] o_cmag [NUM_ELEM],
    output logic               o_cneg [NUM_ELEM]
);

    logic [4:0]         r_vld;
    logic signed [31:0] r_m    [NUM_ELEM];
    logic signed [63:0] r_pa   [NUM_ELEM];
    logic signed [63:0] r_pb   [NUM_ELEM];
    logic signed [31:0] r_mt2  [NUM_TERM];
    logic signed [31:0] r_mt3  [NUM_TERM];
    logic signed [64:0] r_c3   [NUM_ELEM];
    logic signed [64:0] r_c4   [NUM_ELEM];
    logic signed [64:0] r_c5   [NUM_ELEM];
    logic signed [64:0] r_lo   [NUM_TERM];
    logic signed [64:0] r_hi   [NUM_TERM];
    logic signed [97:0] r_det;
    logic signed [97:0] n_det;
    logic signed [97:0] n_dabs;
    t_ctl               r_ctl;
    logic        [96:0] r_dmag;
    logic        [63:0] r_cmag [NUM_ELEM];
    logic               r_cneg [NUM_ELEM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ctl <= '0;
        end else begin
            r_vld       <= {r_vld[3:0], i_valid};
            r_ctl.valid <= r_vld[4];
            r_ctl.singular <= (r_det == '0);
        end
    end

    always_comb begin
        n_det = '0;
        for (int t = 0; t < NUM_TERM; t++) begin
            n_det = n_det + 98'(r_lo[t]) + (98'(r_hi[t]) <<< 32);
        end
        n_dabs = r_det[97] ? -r_det : r_det;
    end

    always_ff @(posedge i_clk) begin
        r_m <= i_m;
        for (int k = 0; k < NUM_ELEM; k++) begin
            r_pa[k] <= r_m[COF_A[k]] * r_m[COF_B[k]];
            r_pb[k] <= r_m[COF_C[k]] * r_m[COF_D[k]];
            r_c3[k] <= $signed({r_pa[k][63], r_pa[k]}) - $signed({r_pb[k][63], r_pb[k]});
            r_c4[k] <= r_c3[k];
            r_c5[k] <= r_c4[k];
            r_cneg[k] <= r_c5[k][64];
            r_cmag[k] <= r_c5[k][64] ? 64'(-r_c5[k]) : 64'(r_c5[k]);
        end
        for (int t = 0; t < NUM_TERM; t++) begin
            r_mt2[t] <= r_m[3*t];
            r_mt3[t] <= r_mt2[t];
            r_lo[t]  <= r_mt3[t] * $signed({1'b0, r_c3[3*t][31:0]});
            r_hi[t]  <= r_mt3[t] * $signed(r_c3[3*t][64:32]);
        end
        r_det  <= n_det;
        r_dmag <= n_dabs[96:0];
    end

    // determinant sign travels with the cofactor sign
    logic r_dneg;
    always_ff @(posedge i_clk) begin
        r_dneg <= r_det[97];
    end

    assign o_ctl  = r_ctl;
    assign o_dmag = r_dmag;
    assign o_cmag = r_cmag;
    always_comb begin
        for (int k = 0; k < NUM_ELEM; k++) begin
            o_cneg[k] = r_cneg[k] ^ r_dneg;
        end
    end

endmodule

### sv/mi3_div_lane.sv
// One divider lane: restoring division of |cofactor|*2^32 by |det|, one
// quotient bit per stage, plus an overflow check. Depends on mi3_pkg.
module mi3_div_lane import mi3_pkg::*; (
    input  logic          i_clk,
    input  logic   [96:0] i_dmag,
    input  logic   [63:0] i_cmag,
    input  logic          i_neg,
    output logic   [32:0] o_q,
    output logic          o_ovf,
    output logic          o_neg
);

    logic [129:0] r_rem [DIV_BITS+1];
    logic  [96:0] r_d   [DIV_BITS+1];
    logic  [32:0] r_q   [DIV_BITS+1];
    logic         r_ovf [DIV_BITS+1];
    logic         r_neg [DIV_BITS+1];

    // overflow when the quotient would need more than DIV_BITS bits
    always_ff @(posedge i_clk) begin
        r_rem[0] <= {34'd0, i_cmag, 32'd0};
        r_d[0]   <= i_dmag;
        r_q[0]   <= '0;
        r_ovf[0] <= {34'd0, i_cmag, 32'd0} >= {i_dmag, 33'd0};
        r_neg[0] <= i_neg;
    end

    for (genvar s = 1; s <= DIV_BITS; s++) begin : g_step
        localparam int SH = DIV_BITS - s;
        logic [129:0] w_dsh;
        assign w_dsh = 130'(r_d[s-1]) << SH;
        always_ff @(posedge i_clk) begin
            if (r_rem[s-1] >= w_dsh) begin
                r_rem[s] <= r_rem[s-1] - w_dsh;
                r_q[s]   <= r_q[s-1] | (33'd1 << SH);
            end else begin
                r_rem[s] <= r_rem[s-1];
                r_q[s]   <= r_q[s-1];
            end
            r_d[s]   <= r_d[s-1];
            r_ovf[s] <= r_ovf[s-1];
            r_neg[s] <= r_neg[s-1];
        end
    end

    assign o_q   = r_q[DIV_BITS];
    assign o_ovf = r_ovf[DIV_BITS];
    assign o_neg = r_neg[DIV_BITS];

endmodule

### sv/mi3_fifo.sv
// Result buffer: memory FIFO with a registered output stage.
// Depends on mi3_pkg.
module mi3_fifo import mi3_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_res i_wdata,
    input  logic i_stall,
    output logic o_valid,
    output t_res o_data
);

    t_res               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_cnt;
    logic               r_ov;
    t_res               r_od;
    logic               w_load;

    assign w_load = (r_cnt != '0) && (!r_ov || !i_stall);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[r_wp] <= i_wdata;
        end
        if (w_load) begin
            r_od <= mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_wp  <= r_wp + FIFO_AW'(i_wr);
            r_rp  <= r_rp + FIFO_AW'(w_load);
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_wr) - (FIFO_AW+1)'(w_load);
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

endmodule

### sv/matrix_inverse_3x3_core.sv
// 3x3 signed Q16.16 matrix inverse: adjugate over determinant.
// Depends on mi3_pkg, mi3_front, mi3_div_lane, mi3_fifo.
//
// Input channel: i_valid / o_stall with the nine elements i_m00..i_m22.
// Output channel: o_valid / i_stall with o_r00..o_r22, o_singular and
// o_saturated. A transfer happens on a clock edge with valid high and
// stall low.
// Throughput: one matrix per cycle while o_stall is low. From the input
// transfer to o_valid a matrix passes six front stages (products, cofactors,
// determinant), nine parallel 34-stage divider lanes, a merge stage and
// the result buffer.
// Every accepted matrix holds a slot in a 64-entry result buffer, so the
// pipeline never stops; o_stall rises once 64 matrices are in flight or
// waiting, and stays high while the receiver stalls.
// Reset (synchronous, active low) empties the pipeline and the buffer.
// A zero determinant returns all zeros with o_singular set.
module matrix_inverse_3x3_core import mi3_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_m00, input logic [31:0] i_m01, input logic [31:0] i_m02,
    input  logic [31:0] i_m10, input logic [31:0] i_m11, input logic [31:0] i_m12,
    input  logic [31:0] i_m20, input logic [31:0] i_m21, input logic [31:0] i_m22,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_r00, output logic [31:0] o_r01, output logic [31:0] o_r02,
    output logic [31:0] o_r10, output logic [31:0] o_r11, output logic [31:0] o_r12,
    output logic [31:0] o_r20, output logic [31:0] o_r21, output logic [31:0] o_r22,
    output logic        o_singular,
    output logic        o_saturated
);

    logic signed [31:0] w_m     [NUM_ELEM];
    t_ctl               w_fctl;
    logic        [96:0] w_dmag;
    logic        [63:0] w_cmag  [NUM_ELEM];
    logic               w_cneg  [NUM_ELEM];
    logic        [32:0] w_q     [NUM_ELEM];
    logic               w_ovf   [NUM_ELEM];
    logic               w_neg   [NUM_ELEM];
    t_ctl               r_ctl   [LANE_LAT];
    t_res               r_res;
    t_res               n_res;
    logic               r_res_vld;
    t_res               w_out;
    logic [CREDIT_W-1:0] r_credit;
    logic               w_acc;
    logic               w_dlv;

    assign w_m = '{$signed(i_m00), $signed(i_m01), $signed(i_m02),
                   $signed(i_m10), $signed(i_m11), $signed(i_m12),
                   $signed(i_m20), $signed(i_m21), $signed(i_m22)};

    assign o_stall = (r_credit == CREDIT_W'(FIFO_DEPTH));
    assign w_acc   = i_valid && !o_stall;
    assign w_dlv   = o_valid && !i_stall;

    mi3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_acc),
        .i_m     (w_m),
        .o_ctl   (w_fctl),
        .o_dmag  (w_dmag),
        .o_cmag  (w_cmag),
        .o_cneg  (w_cneg)
    );

    // lane L = row*3 + col takes the transposed cofactor col*3 + row
    for (genvar l = 0; l < NUM_ELEM; l++) begin : g_lane
        localparam int CI = (l % 3) * 3 + l / 3;
        mi3_div_lane u_lane (
            .i_clk  (i_clk),
            .i_dmag (w_dmag),
            .i_cmag (w_cmag[CI]),
            .i_neg  (w_cneg[CI]),
            .o_q    (w_q[l]),
            .o_ovf  (w_ovf[l]),
            .o_neg  (w_neg[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LANE_LAT; s++) begin
                r_ctl[s] <= '0;
            end
            r_res_vld <= 1'b0;
            r_credit  <= '0;
        end else begin
            r_ctl[0] <= w_fctl;
            for (int s = 1; s < LANE_LAT; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
            r_res_vld <= r_ctl[LANE_LAT-1].valid;
            r_credit  <= r_credit + CREDIT_W'(w_acc) - CREDIT_W'(w_dlv);
        end
    end

    // merge: sign, clip and the singular override across all lanes
    always_comb begin
        n_res = '0;
        n_res.singular = r_ctl[LANE_LAT-1].singular;
        for (int l = 0; l < NUM_ELEM; l++) begin
            if (!r_ctl[LANE_LAT-1].singular) begin
                if (!w_neg[l]) begin
                    if (w_ovf[l] || w_q[l][32] || w_q[l][31]) begin
                        n_res.r[l] = 32'h7FFF_FFFF;
                        n_res.saturated = 1'b1;
                    end else begin
                        n_res.r[l] = w_q[l][31:0];
                    end
                end else begin
                    if (w_ovf[l] || (w_q[l] > 33'h0_8000_0000)) begin
                        n_res.r[l] = 32'h8000_0000;
                        n_res.saturated = 1'b1;
                    end else begin
                        n_res.r[l] = 32'd0 - w_q[l][31:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    mi3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (r_res_vld),
        .i_wdata (r_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (w_out)
    );

    assign o_r00 = w_out.r[0];
    assign o_r01 = w_out.r[1];
    assign o_r02 = w_out.r[2];
    assign o_r10 = w_out.r[3];
    assign o_r11 = w_out.r[4];
    assign o_r12 = w_out.r[5];
    assign o_r20 = w_out.r[6];
    assign o_r21 = w_out.r[7];
    assign o_r22 = w_out.r[8];
    assign o_singular  = w_out.singular;
    assign o_saturated = w_out.saturated;

    a_credit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CREDIT_W'(FIFO_DEPTH))
        else $error("credit count above buffer depth");

    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_credit != '0))
        else $error("result shown with no matrix in flight");

    a_singular_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (!o_saturated && o_r00 == '0 && o_r22 == '0))
        else $error("singular result not cleared");

endmodule

### verif/tb_top.sv
// Self-checking testbench for matrix_inverse_3x3_core (Q16.16 3x3 inverse).
// Depends on mi3_pkg and the core RTL; predicts each inverse with wide exact arithmetic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mi3_pkg::*;

    typedef struct {
        logic [31:0] r [9];
        logic        singular;
        logic        saturated;
    } t_inv;

    class inverse_board;
        t_inv pending [$];
        int   errors = 0;

        // Exact adjugate over determinant, truncated and saturated.
        function t_inv predict(logic [31:0] m [9]);
            t_inv res;
            logic signed [127:0] e [9];
            logic signed [127:0] c [9];
            logic signed [127:0] det, num, q, dmag, cmag;
            logic neg;
            for (int k = 0; k < 9; k++) e[k] = {{96{m[k][31]}}, m[k]};
            for (int k = 0; k < 9; k++)
                c[k] = e[COF_A[k]] * e[COF_B[k]] - e[COF_C[k]] * e[COF_D[k]];
            det = e[0] * c[0] + e[3] * c[3] + e[6] * c[6];
            res.singular = (det == 0);
            res.saturated = 1'b0;
            for (int k = 0; k < 9; k++) res.r[k] = '0;
            if (det != 0) begin
                dmag = det < 0 ? -det : det;
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        cmag = c[j*3+i] < 0 ? -c[j*3+i] : c[j*3+i];
                        neg = (c[j*3+i] < 0) != (det < 0);
                        num = cmag <<< 32;
                        q = num / dmag;
                        if (!neg) begin
                            if (q > 128'sh7FFFFFFF) begin
                                res.r[i*3+j] = 32'h7FFFFFFF; res.saturated = 1'b1;
                            end else res.r[i*3+j] = q[31:0];
                        end else begin
                            if (q > 128'sh80000000) begin
                                res.r[i*3+j] = 32'h80000000; res.saturated = 1'b1;
                            end else res.r[i*3+j] = -q[31:0];
                        end
                    end
                end
            end
            return res;
        endfunction

        function void note_matrix(logic [31:0] m [9]);
            pending.push_back(predict(m));
        endfunction

        function void check_inverse(t_inv got);
            t_inv want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result", $time);
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int k = 0; k < 9; k++)
                if (got.r[k] !== want.r[k]) begin
                    $display("%0t: r%0d%0d expected %h actual %h", $time, k/3, k%3,
                             want.r[k], got.r[k]);
                    errors++;
                end
            if (got.singular !== want.singular) begin
                $display("%0t: singular expected %b actual %b", $time, want.singular,
                         got.singular);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                         got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0, i_rst_n = 0, i_valid = 0, i_stall = 0;
    logic [31:0] mx [9];
    logic        o_stall, o_valid, o_singular, o_saturated;
    logic [31:0] ro [9];
    inverse_board board = new();
    bit          feed_done = 0, drain_on = 1;
    int          idle_cycles = 0;

    initial for (int k = 0; k < 9; k++) mx[k] = '0;

    matrix_inverse_3x3_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_m00(mx[0]), .i_m01(mx[1]), .i_m02(mx[2]),
        .i_m10(mx[3]), .i_m11(mx[4]), .i_m12(mx[5]),
        .i_m20(mx[6]), .i_m21(mx[7]), .i_m22(mx[8]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_r00(ro[0]), .o_r01(ro[1]), .o_r02(ro[2]),
        .o_r10(ro[3]), .o_r11(ro[4]), .o_r12(ro[5]),
        .o_r20(ro[6]), .o_r21(ro[7]), .o_r22(ro[8]),
        .o_singular(o_singular), .o_saturated(o_saturated)
    );

    initial forever #2 i_clk = ~i_clk;

    function automatic int gap_len();
        int p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // Hold one matrix on the inputs until it transfers.
    task automatic send_matrix(logic [31:0] m [9]);
        int g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        for (int k = 0; k < 9; k++) mx[k] <= m[k];
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_matrix(m);
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return {{16{1'b0}}, 16'h0000} + ($urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000);
            3: return $urandom_range(0, 15);
            4: return 32'(signed'($urandom_range(0, 2**20)) - 2**19);
            default: return $urandom();
        endcase
    endfunction

    task automatic run_stimulus();
        logic [31:0] m [9];
        // identity, zero, extremes
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? 32'h00010000 : 32'h0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = 32'h0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = 32'h80000000;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? 32'h80000000 : 32'h0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? 32'h7FFFFFFF : 32'h0;
        send_matrix(m);
        // tiny determinant drives saturation both ways
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? 32'h00000001 : 32'h0;
        send_matrix(m);
        m[4] = 32'hFFFFFFFF; m[1] = 32'h7FFFFFFF;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? 32'h00020000 : 32'hFFFFFFFF;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = 32'hFFFFFFFF ^ (k << 5);
        send_matrix(m);
        for (int n = 0; n < 1300; n++) begin
            for (int k = 0; k < 9; k++) m[k] = rand_elem();
            // duplicated rows give singular matrices now and then
            if ($urandom_range(0, 9) == 0) for (int k = 0; k < 3; k++) m[3+k] = m[k];
            send_matrix(m);
            if (n == 600) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (board.pending.size() != 0) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
    endtask

    // Receiver stall pattern
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            g = gap_len();
            if (g > 0) begin
                i_stall <= 1'b1;
                repeat (g) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_inv got;
        if (i_rst_n && o_valid && !i_stall) begin
            for (int k = 0; k < 9; k++) got.r[k] = ro[k];
            got.singular = o_singular;
            got.saturated = o_saturated;
            board.check_inverse(got);
        end
        if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_stimulus();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

### matrix_inverse_3x3_core.f
sv/mi3_pkg.sv
sv/mi3_front.sv
sv/mi3_div_lane.sv
sv/mi3_fifo.sv
sv/matrix_inverse_3x3_core.sv
verif/tb_top.sv
